// ----- hdl/tlag_pkg.sv -----
// Shared types and constants for the tiled/linear address generator.
`timescale 1ns / 1ps

package tlag_pkg;

	localparam int TILE_SIZE_DEF = 32;
	localparam int DIM_W         = 16;
	// Pixel coordinate width: the largest coordinate stays below 65535 + 64.
	localparam int COORD_W       = 17;
	localparam int COUNT_W       = 32;
	localparam int ADDR_W        = 34;
	localparam int BPP_W         = 2;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP_LOG2     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TO_TILED     = 2'd3;

	localparam logic [BPP_W-1:0] BPP_LOG2_MAX = 2'd2;

	// Position of the pixel handed out for the current request.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COUNT_W-1:0] count;
		logic               last;
	} pix_pos_t;

endpackage

// ----- hdl/tiled_linear_address_generator_top.sv -----
// Top level of the tiled/linear address generator with config registers and output stage.
`timescale 1ns / 1ps

// Produces one read/write byte-offset pair per accepted request, walking the
// image in square tiles (row by row of tiles, row by row inside a tile) with
// clipped edge tiles. The walk counters and the y*width multiply sit between
// the position registers and a single output register, so a new request is
// taken every clock while the output is not stalled. restart=1 makes the
// request return the first pixel; last_pixel marks the final pixel, after
// which the walk starts over.
// Configuration must be written while no request is in flight.

module tiled_linear_address_generator_top import tlag_pkg::*; #(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    read_address,
	output logic [ADDR_W-1:0]    write_address,
	output logic                 last_pixel
);

	logic [DIM_W-1:0] width_q, height_q, width_eff, height_eff;
	logic [BPP_W-1:0] bpp_log2_q, shift;
	logic             to_tiled_q;
	logic             accept, out_valid_q;
	pix_pos_t         pos;

	logic [2*DIM_W:0]  prod;
	logic [ADDR_W-1:0] lin_idx, lin_addr, til_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_W'(1);
			height_q   <= DIM_W'(1);
			bpp_log2_q <= BPP_LOG2_MAX;
			to_tiled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q    <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q   <= cfg_data;
				CFG_BPP_LOG2:     bpp_log2_q <= cfg_data[BPP_W-1:0];
				CFG_TO_TILED:     to_tiled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_eff  = (width_q == '0) ? DIM_W'(1) : width_q;
		height_eff = (height_q == '0) ? DIM_W'(1) : height_q;
		shift      = (bpp_log2_q > BPP_LOG2_MAX) ? BPP_LOG2_MAX : bpp_log2_q;
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	tlag_walk #(
		.TILE_SIZE(TILE_SIZE)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.restart(restart),
		.width  (width_eff),
		.height (height_eff),
		.pos    (pos)
	);

	// Addresses are truncated to ADDR_W bits.
	always_comb begin
		prod     = (2*DIM_W+1)'(pos.y) * (2*DIM_W+1)'(width_eff);
		lin_idx  = ADDR_W'(prod) + ADDR_W'(pos.x);
		lin_addr = lin_idx << shift;
		til_addr = ADDR_W'(pos.count) << shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_address  <= to_tiled_q ? lin_addr : til_addr;
			write_address <= to_tiled_q ? til_addr : lin_addr;
			last_pixel    <= pos.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/tlag_walk.sv -----
// Tiled-order walk counters: tile and in-tile position plus running pixel count.
`timescale 1ns / 1ps

module tlag_walk import tlag_pkg::*; #(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             restart,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	output pix_pos_t         pos
);

	localparam int CW  = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
	localparam int TCW = $clog2((65535 + TILE_SIZE - 1) / TILE_SIZE);
	localparam logic [COORD_W-1:0] TILE_C  = COORD_W'(TILE_SIZE);
	localparam logic [CW:0]        TILE_CI = (CW+1)'(TILE_SIZE);

	logic [TCW-1:0]     tile_row_q, tile_col_q, tr, tc;
	logic [CW-1:0]      row_in_tile_q, col_in_tile_q, rit, cit;
	logic [COUNT_W-1:0] pixel_count_q, cnt;

	logic [CW:0]        cit_inc, rit_inc;
	logic [TCW:0]       tc_inc, tr_inc;
	logic [COORD_W:0]   x_inc, y_inc;
	logic [COORD_W-1:0] x, y, tc_span, tr_span;
	logic               col_wrap, row_wrap, tcol_wrap, trow_wrap, last;

	// Restart clears the walk before this pixel is produced.
	always_comb begin
		tr  = restart ? '0 : tile_row_q;
		tc  = restart ? '0 : tile_col_q;
		rit = restart ? '0 : row_in_tile_q;
		cit = restart ? '0 : col_in_tile_q;
		cnt = restart ? '0 : pixel_count_q;
	end

	always_comb begin
		x       = COORD_W'(tc) * TILE_C + COORD_W'(cit);
		y       = COORD_W'(tr) * TILE_C + COORD_W'(rit);
		x_inc   = {1'b0, x} + 1'b1;
		y_inc   = {1'b0, y} + 1'b1;
		cit_inc = {1'b0, cit} + 1'b1;
		rit_inc = {1'b0, rit} + 1'b1;
		tc_inc  = {1'b0, tc} + 1'b1;
		tr_inc  = {1'b0, tr} + 1'b1;
		tc_span = COORD_W'(tc_inc) * TILE_C;
		tr_span = COORD_W'(tr_inc) * TILE_C;

		col_wrap  = (cit_inc >= TILE_CI) || (x_inc >= (COORD_W+1)'(width));
		row_wrap  = (rit_inc >= TILE_CI) || (y_inc >= (COORD_W+1)'(height));
		tcol_wrap = tc_span >= COORD_W'(width);
		trow_wrap = tr_span >= COORD_W'(height);
		last      = col_wrap && row_wrap && tcol_wrap && trow_wrap;

		pos.x     = x;
		pos.y     = y;
		pos.count = cnt;
		pos.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_row_q    <= '0;
			tile_col_q    <= '0;
			row_in_tile_q <= '0;
			col_in_tile_q <= '0;
			pixel_count_q <= '0;
		end else if (step) begin
			pixel_count_q <= cnt + 1'b1;
			tile_row_q    <= tr;
			tile_col_q    <= tc;
			row_in_tile_q <= rit;
			if (!col_wrap) begin
				col_in_tile_q <= cit_inc[CW-1:0];
			end else begin
				col_in_tile_q <= '0;
				if (!row_wrap) begin
					row_in_tile_q <= rit_inc[CW-1:0];
				end else begin
					row_in_tile_q <= '0;
					if (!tcol_wrap) begin
						tile_col_q <= tc_inc[TCW-1:0];
					end else begin
						tile_col_q <= '0;
						if (!trow_wrap) begin
							tile_row_q <= tr_inc[TCW-1:0];
						end else begin
							// final pixel: walk starts over
							tile_row_q    <= '0;
							pixel_count_q <= '0;
						end
					end
				end
			end
		end
	end

endmodule
